FILE: rtl/hp_vad_pkg.sv
package hp_vad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int HP_TAPS  = 11;
  localparam int HP_HALF  = 6;
  localparam int HP_SHIFT = 12;
  localparam int ACC_W    = 29;
  localparam int ENERGY_W = 40;
  localparam int SQ_W     = 31;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 64;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [ENERGY_W-1:0]        energy_t;
  typedef logic [SQ_W-1:0]            square_t;
  typedef logic [1:0]                 kind_t;
  typedef logic [1:0]                 verdict_t;

  localparam kind_t KIND_NORMAL = 2'd0;
  localparam kind_t KIND_TONE   = 2'd1;
  localparam kind_t KIND_MUTED  = 2'd2;

  localparam verdict_t VERDICT_SILENT = 2'd0;
  localparam verdict_t VERDICT_ACTIVE = 2'd1;
  localparam verdict_t VERDICT_TONE   = 2'd2;

  // register index taken from paddr[3]
  localparam logic REG_MIN_ENERGY = 1'b0;

  localparam energy_t ENERGY_MAX = {ENERGY_W{1'b1}};

  // symmetric highpass, Q12; entry k weights taps k and 10-k
  localparam acc_t HP_COEF [HP_HALF] = '{
    acc_t'(15), acc_t'(0), acc_t'(-123), acc_t'(-446), acc_t'(-844), acc_t'(1542)
  };

  typedef struct packed {
    logic  sat_en;
    logic  sqr_en;
    logic  commit;
    logic  last;
    kind_t kind;
  } hp_ctrl_t;

endpackage

FILE: rtl/hp_vad_ifs.sv
interface hp_in_if;
  import hp_vad_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  kind_t   frame_kind;
  logic    frame_end;

  modport source (output valid, output sample, output frame_kind, output frame_end,
                  input ready);
  modport sink (input valid, input sample, input frame_kind, input frame_end,
                output ready);
endinterface

interface hp_out_if;
  import hp_vad_pkg::*;

  logic     valid;
  logic     ready;
  sample_t  filtered_sample;
  logic     verdict_valid;
  verdict_t verdict;

  modport source (output valid, output filtered_sample, output verdict_valid,
                  output verdict, input ready);
  modport sink (input valid, input filtered_sample, input verdict_valid,
                input verdict, output ready);
endinterface

FILE: rtl/hp_tap_cell.sv
module hp_tap_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift_en,
  input  hp_vad_pkg::sample_t  din,
  output hp_vad_pkg::sample_t  dout
);
  import hp_vad_pkg::*;

  sample_t tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (shift_en) begin
      tap <= din;
    end
  end

  assign dout = tap;

endmodule

FILE: rtl/hp_energy.sv
module hp_energy (
  input  logic                  clk,
  input  logic                  rst,
  input  hp_vad_pkg::hp_ctrl_t  ctrl,
  input  hp_vad_pkg::acc_t      acc,
  input  hp_vad_pkg::energy_t   threshold,
  output hp_vad_pkg::sample_t   filtered,
  output hp_vad_pkg::verdict_t  verdict
);
  import hp_vad_pkg::*;

  sample_t  prev;
  energy_t  energy;
  logic     pairs;
  logic     frame_start;

  sample_t  y;
  sample_t  half_diff;
  square_t  square;

  logic signed [SAMPLE_W:0]     q;
  sample_t                      y_sat;
  logic signed [SAMPLE_W:0]     diff;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [ENERGY_W:0]            e_sum;
  energy_t                      e_sat;

  sample_t  prev_next;
  energy_t  energy_next;
  logic     pairs_next;
  logic     frame_start_next;
  energy_t  e_upd;
  logic     pairs_upd;
  logic     normal;

  assign normal = (ctrl.kind == KIND_NORMAL);

  // floor shift then clamp to 16 bits
  always_comb begin
    q = (SAMPLE_W+1)'(acc >>> HP_SHIFT);
    if (q > (SAMPLE_W+1)'(32767)) begin
      y_sat = sample_t'(16'sh7FFF);
    end else if (q < -(SAMPLE_W+1)'(32768)) begin
      y_sat = sample_t'(16'sh8000);
    end else begin
      y_sat = q[SAMPLE_W-1:0];
    end
    diff = (SAMPLE_W+1)'(prev) - (SAMPLE_W+1)'(y_sat);
  end

  assign sq_full = (2*SAMPLE_W)'(half_diff) * (2*SAMPLE_W)'(half_diff);
  assign e_sum   = (ENERGY_W+1)'(energy) + (ENERGY_W+1)'(square);
  assign e_sat   = e_sum[ENERGY_W] ? ENERGY_MAX : e_sum[ENERGY_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.sat_en) begin
      y         <= y_sat;
      half_diff <= SAMPLE_W'(diff >>> 1);
    end
    if (ctrl.sqr_en) begin
      square <= SQ_W'(sq_full);
    end
  end

  always_comb begin
    e_upd       = energy;
    pairs_upd   = pairs;
    prev_next   = prev;
    frame_start_next = frame_start;
    verdict     = VERDICT_SILENT;
    if (normal) begin
      if (!frame_start) begin
        e_upd     = e_sat;
        pairs_upd = 1'b1;
      end
      prev_next        = y;
      frame_start_next = 1'b0;
    end
    energy_next = e_upd;
    pairs_next  = pairs_upd;
    if (ctrl.last) begin
      if (normal) begin
        verdict = (pairs_upd && (e_upd >= threshold)) ? VERDICT_ACTIVE : VERDICT_SILENT;
      end else if (ctrl.kind == KIND_TONE) begin
        verdict = VERDICT_TONE;
      end else begin
        verdict = VERDICT_SILENT;
      end
      energy_next      = '0;
      pairs_next       = 1'b0;
      frame_start_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev        <= '0;
      energy      <= '0;
      pairs       <= 1'b0;
      frame_start <= 1'b1;
    end else if (ctrl.commit) begin
      prev        <= prev_next;
      energy      <= energy_next;
      pairs       <= pairs_next;
      frame_start <= frame_start_next;
    end
  end

  assign filtered = normal ? y : '0;

endmodule

FILE: rtl/highpass_fir_voice_detect_top.sv
// Highpass FIR with energy voice detection. One microphone sample is taken per request on
// mic and one result per sample leaves on vad. A sample runs through a six-step sequencer:
// accept and shift a normal sample into the 11-cell tap chain, symmetric-pair products,
// sum, floor shift with saturation and halved difference, square, then energy update
// and verdict. The next sample is taken once the result sits in the output register; a
// stalled vad holds the final step. The 40-bit threshold min_voice_energy sits at byte
// address 0 of the APB port (64-bit data); the user is to write it only while no sample
// is in flight, which the block itself does not enforce.
module highpass_fir_voice_detect_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hp_vad_pkg::PADDR_W-1:0]    paddr,
  input  logic [hp_vad_pkg::PDATA_W-1:0]    pwdata,
  output logic [hp_vad_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready,
  hp_in_if.sink                             mic,
  hp_out_if.source                          vad
);
  import hp_vad_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_SAT, S_SQR, S_DONE
  } state_t;

  state_t   state;
  kind_t    kind;
  logic     last;
  energy_t  min_voice_energy;

  logic     out_valid;
  sample_t  out_sample;
  logic     out_vvalid;
  verdict_t out_verdict;

  sample_t  taps [HP_TAPS];
  acc_t     prod [HP_HALF];
  acc_t     acc;

  logic     accept;
  logic     commit;
  hp_ctrl_t ctrl;
  sample_t  filtered;
  verdict_t verdict;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_MIN_ENERGY) ? PDATA_W'(min_voice_energy) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_voice_energy <= '0;
    end else if (psel && penable && pwrite && (paddr[3] == REG_MIN_ENERGY)) begin
      min_voice_energy <= pwdata[ENERGY_W-1:0];
    end
  end

  assign mic.ready = (state == S_IDLE);
  assign accept    = mic.valid && mic.ready;
  assign commit    = (state == S_DONE) && (!out_valid || vad.ready);

  // tap chain: newest sample enters the top cell
  for (genvar k = 0; k < HP_TAPS; k++) begin : g_tap
    if (k == HP_TAPS - 1) begin : g_head
      hp_tap_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (accept && (mic.frame_kind == KIND_NORMAL)),
        .din      (mic.sample),
        .dout     (taps[k])
      );
    end else begin : g_body
      hp_tap_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (accept && (mic.frame_kind == KIND_NORMAL)),
        .din      (taps[k+1]),
        .dout     (taps[k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      for (int k = 0; k < HP_HALF; k++) begin
        prod[k] <= (acc_t'(taps[k]) + acc_t'(taps[HP_TAPS-1-k])) * HP_COEF[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SUM) begin
      acc <= prod[0] + prod[1] + prod[2] + prod[3] + prod[4] + prod[5];
    end
  end

  assign ctrl.sat_en = (state == S_SAT);
  assign ctrl.sqr_en = (state == S_SQR);
  assign ctrl.commit = commit;
  assign ctrl.last   = last;
  assign ctrl.kind   = kind;

  hp_energy u_energy (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .acc       (acc),
    .threshold (min_voice_energy),
    .filtered  (filtered),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (vad.valid && vad.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (mic.valid) begin
            kind  <= mic.frame_kind;
            last  <= mic.frame_end;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_SUM;
        S_SUM: state <= S_SAT;
        S_SAT: state <= S_SQR;
        S_SQR: state <= S_DONE;
        S_DONE: begin
          if (commit) begin
            out_valid   <= 1'b1;
            out_sample  <= filtered;
            out_vvalid  <= last;
            out_verdict <= verdict;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign vad.valid           = out_valid;
  assign vad.filtered_sample = out_sample;
  assign vad.verdict_valid   = out_vvalid;
  assign vad.verdict         = out_verdict;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import hp_vad_pkg::*;

  localparam kind_t KIND_RESERVED = 2'd3;
  localparam int IDLE_PCT = 12;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int SAT_FRAME_LEN = 40;
  localparam logic [PADDR_W-1:0] MIN_ENERGY_ADDR = {REG_MIN_ENERGY, 3'b000};
  // half of the symmetric tap set, Q12; entry k pairs taps k and 10-k
  localparam int TAP_WEIGHT [6] = '{15, 0, -123, -446, -844, 1542};

  typedef struct {
    sample_t sample;
    kind_t   kind;
    logic    last;
  } mic_req_t;

  typedef struct {
    sample_t  filtered;
    logic     verdict_valid;
    verdict_t verdict;
  } vad_result_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  hp_in_if  mic ();
  hp_out_if vad ();

  highpass_fir_voice_detect_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mic     (mic),
    .vad     (vad)
  );

  mic_req_t    pending_reqs [$];
  vad_result_t expected_results [$];
  mic_req_t    next_req;
  vad_result_t want_result;

  // filter and detector state mirrored from the block
  sample_t tap_hist [10];
  sample_t prev_filtered;
  energy_t frame_energy;
  logic    pair_seen;
  logic    at_frame_start;
  energy_t min_energy;
  energy_t energy_at_end;

  logic calm;
  int   errors;
  int   results_seen;
  int   hold_left;
  logic hold_done;
  int   quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic vad_result_t filter_and_detect(sample_t x, kind_t kind, logic last);
    vad_result_t res;
    int          win [11];
    int          acc;
    int          y;
    int          d;
    longint      sq;
    logic [40:0] sum;
    int          k;
    res.filtered = '0;
    res.verdict_valid = last;
    res.verdict = VERDICT_SILENT;
    if (kind == KIND_NORMAL) begin
      for (k = 0; k < 10; k++) win[k] = int'(tap_hist[k]);
      win[10] = int'(x);
      acc = 0;
      for (k = 0; k < 6; k++) acc += (win[k] + win[10-k]) * TAP_WEIGHT[k];
      y = acc >>> HP_SHIFT;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      for (k = 0; k < 9; k++) tap_hist[k] = tap_hist[k+1];
      tap_hist[9] = x;
      if (!at_frame_start) begin
        d = (int'(prev_filtered) - y) >>> 1;
        sq = longint'(d) * longint'(d);
        sum = 41'(frame_energy) + 41'(sq);
        frame_energy = (sum > 41'(ENERGY_MAX)) ? ENERGY_MAX : sum[ENERGY_W-1:0];
        pair_seen = 1'b1;
      end
      prev_filtered = sample_t'(y);
      at_frame_start = 1'b0;
      res.filtered = sample_t'(y);
    end
    if (last) begin
      if (kind == KIND_NORMAL)
        res.verdict = (pair_seen && frame_energy >= min_energy) ? VERDICT_ACTIVE : VERDICT_SILENT;
      else if (kind == KIND_TONE)
        res.verdict = VERDICT_TONE;
      energy_at_end = frame_energy;
      frame_energy = '0;
      pair_seen = 1'b0;
      at_frame_start = 1'b1;
    end
    return res;
  endfunction

  // sample source
  always @(posedge clk) begin
    if (rst) begin
      mic.valid <= 1'b0;
      foreach (tap_hist[i]) tap_hist[i] = '0;
      prev_filtered = '0;
      frame_energy = '0;
      pair_seen = 1'b0;
      at_frame_start = 1'b1;
      min_energy = '0;
    end else begin
      if (mic.valid && mic.ready)
        expected_results.push_back(filter_and_detect(mic.sample, mic.frame_kind,
                                                     mic.frame_end));
      if (!mic.valid || mic.ready) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_req = pending_reqs.pop_front();
          mic.valid      <= 1'b1;
          mic.sample     <= next_req.sample;
          mic.frame_kind <= next_req.kind;
          mic.frame_end  <= next_req.last;
        end else begin
          mic.valid <= 1'b0;
        end
      end
    end
  end

  // result sink and checker
  always @(posedge clk) begin
    if (rst) begin
      vad.ready <= 1'b0;
    end else begin
      if (vad.valid && vad.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual %0d/%0b/%0d", $time,
                   vad.filtered_sample, vad.verdict_valid, vad.verdict);
        end else begin
          want_result = expected_results.pop_front();
          if (vad.filtered_sample !== want_result.filtered ||
              vad.verdict_valid !== want_result.verdict_valid ||
              vad.verdict !== want_result.verdict) begin
            errors++;
            $display("%0t result mismatch (sample/end/verdict): expected %0d/%0b/%0d actual %0d/%0b/%0d",
                     $time, want_result.filtered, want_result.verdict_valid,
                     want_result.verdict, vad.filtered_sample, vad.verdict_valid, vad.verdict);
          end
        end
      end
      // one long back-pressure stretch so the sample side fills and stalls
      if (hold_left > 0) begin
        hold_left--;
        vad.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        vad.ready <= 1'b0;
      end else begin
        vad.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (mic.valid && mic.ready) || (vad.valid && vad.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic sample_t rand_sample(int amp);
    if (amp >= 32768) return sample_t'($urandom);
    return sample_t'(int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  task automatic push_req(sample_t s, kind_t k, logic last);
    mic_req_t req;
    req.sample = s;
    req.kind = k;
    req.last = last;
    pending_reqs.push_back(req);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || mic.valid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // write the threshold, then read it back
  task automatic set_threshold(energy_t v);
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= MIN_ENERGY_ADDR;
    pwdata <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    min_energy = v;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== PDATA_W'(v)) begin
      errors++;
      $display("%0t threshold readback: expected %0h actual %0h", $time, v, prdata);
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // zero history with a ten-sample frame, then the probe frame
  task automatic push_probe(const ref sample_t probe [12]);
    int i;
    for (i = 0; i < 10; i++) push_req('0, KIND_NORMAL, i == 9);
    for (i = 0; i < 12; i++) push_req(probe[i], KIND_NORMAL, i == 11);
  endtask

  task automatic add_random_frames(int count);
    int    made;
    int    len;
    int    pick;
    int    amp;
    int    i;
    logic  alt;
    kind_t k;
    made = 0;
    while (made < count) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 32);
      pick = $urandom_range(99);
      amp = 1 << $urandom_range(0, 15);
      if ($urandom_range(9) == 0) amp = 0;
      alt = ($urandom_range(9) == 0);
      for (i = 0; i < len; i++) begin
        if (pick < 70) k = KIND_NORMAL;
        else if (pick < 82) k = KIND_TONE;
        else if (pick < 92) k = KIND_MUTED;
        else if (pick < 95) k = KIND_RESERVED;
        else k = kind_t'($urandom_range(3));
        push_req(alt ? ((i % 2 == 0) ? sample_t'(32767) : sample_t'(-32768))
                     : rand_sample(amp), k, i == len - 1);
      end
      made += len;
    end
  endtask

  sample_t probe_frame [12];
  energy_t probe_energy;

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mic.valid = 1'b0;
    mic.sample = '0;
    mic.frame_kind = KIND_NORMAL;
    mic.frame_end = 1'b0;
    vad.ready = 1'b0;
    calm = 1'b0;
    errors = 0;
    results_seen = 0;
    hold_left = 0;
    hold_done = 1'b0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset threshold: 1-sample frame silent, 5-sample active, tone frame TONE
    push_req(sample_t'(32767), KIND_NORMAL, 1'b1);
    push_req(sample_t'(32767), KIND_NORMAL, 1'b0);
    push_req(sample_t'(-32768), KIND_NORMAL, 1'b0);
    push_req(sample_t'(0), KIND_NORMAL, 1'b0);
    push_req(sample_t'(32767), KIND_NORMAL, 1'b0);
    push_req(sample_t'(-32768), KIND_NORMAL, 1'b1);
    push_req(sample_t'(-32768), KIND_TONE, 1'b0);
    push_req(sample_t'(32767), KIND_TONE, 1'b1);
    push_req(sample_t'(12345), KIND_MUTED, 1'b0);
    push_req(sample_t'(-1), KIND_MUTED, 1'b1);
    push_req(sample_t'(1), KIND_RESERVED, 1'b0);
    push_req(sample_t'(-32768), KIND_RESERVED, 1'b1);
    // mixed kinds: pairs skip tone and muted samples, verdict by the last kind
    push_req(sample_t'(100), KIND_NORMAL, 1'b0);
    push_req(sample_t'(5), KIND_TONE, 1'b0);
    push_req(sample_t'(-200), KIND_NORMAL, 1'b0);
    push_req(sample_t'(7), KIND_MUTED, 1'b0);
    push_req(sample_t'(300), KIND_NORMAL, 1'b1);
    push_req(sample_t'(50), KIND_NORMAL, 1'b0);
    push_req(sample_t'(-50), KIND_NORMAL, 1'b0);
    push_req(sample_t'(0), KIND_TONE, 1'b1);
    push_req(sample_t'(1000), KIND_NORMAL, 1'b0);
    push_req(sample_t'(-1000), KIND_NORMAL, 1'b0);
    push_req(sample_t'(-1), KIND_MUTED, 1'b1);
    wait_drained();

    // same frame against a zero threshold, its own energy and one above it
    foreach (probe_frame[i]) probe_frame[i] = rand_sample(300);
    set_threshold('0);
    push_probe(probe_frame);
    wait_drained();
    probe_energy = energy_at_end;
    set_threshold(probe_energy);
    push_probe(probe_frame);
    wait_drained();
    set_threshold(probe_energy + 1);
    push_probe(probe_frame);
    wait_drained();

    set_threshold(energy_t'(1) << 20);
    add_random_frames(210);
    wait_drained();

    set_threshold(energy_t'(1) << 30);
    calm <= 1'b1;
    add_random_frames(210);
    wait_drained();
    calm <= 1'b0;

    set_threshold({8'($urandom_range(255)), $urandom});
    add_random_frames(210);
    wait_drained();

    set_threshold('0);
    add_random_frames(210);
    wait_drained();

    // full-swing alternating frame against the largest threshold
    set_threshold(ENERGY_MAX);
    for (int i = 0; i < SAT_FRAME_LEN; i++)
      push_req((i % 2 == 0) ? sample_t'(32767) : sample_t'(-32768), KIND_NORMAL,
               i == SAT_FRAME_LEN - 1);
    for (int i = 0; i < 20; i++) push_req(rand_sample(32768), KIND_NORMAL, i == 19);
    wait_drained();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
